// File: rtl/core/mrbce_pkg.sv
// Package for the mask run blit code emitter.
// Holds the item types, command codes, microcode control word layout and
// entry points, and the MOVEM register mask table. No dependencies.
package mrbce_pkg;

  localparam int unsigned UPC_W = 5;
  localparam int unsigned RUN_W = 6;
  localparam int unsigned OFF_W = 9;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_PIXEL  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [RUN_W-1:0] RUN_FLUSH = RUN_W'(44);

  localparam logic [UPC_W-1:0] UA_PRE   = UPC_W'(0);
  localparam logic [UPC_W-1:0] UA_POST  = UPC_W'(5);
  localparam logic [UPC_W-1:0] UA_CHUNK = UPC_W'(8);
  localparam logic [UPC_W-1:0] UA_M_OFF = UPC_W'(9);
  localparam logic [UPC_W-1:0] UA_M_0   = UPC_W'(15);
  localparam logic [UPC_W-1:0] UA_S_OFF = UPC_W'(19);
  localparam logic [UPC_W-1:0] UA_S_0   = UPC_W'(22);
  localparam logic [UPC_W-1:0] UA_TAIL  = UPC_W'(23);

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] mask_byte;
    logic       line_end;
    logic       last_line;
  } in_t;

  typedef struct packed {
    logic [15:0] code_word;
    logic        last_word;
  } out_t;

  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_MASK,
    SRC_OFF,
    SRC_LOP,
    SRC_SOP
  } src_e;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_CHUNK
  } last_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ADV,
    ACT_FIN
  } act_e;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_GOTO,
    SEQ_DONE,
    SEQ_DISPATCH,
    SEQ_TAIL
  } seq_e;

  typedef struct packed {
    logic             emit;
    src_e             src;
    logic [15:0]      lit;
    last_e            last;
    act_e             act;
    seq_e             seq;
    logic [UPC_W-1:0] tgt;
  } ctrl_t;

  // Register mask for a MOVEM pair, chosen by the chunk size in longwords.
  function automatic logic [15:0] movem_mask(input logic [3:0] longs);
    logic [15:0] m;
    case (longs)
      4'd3:    m = 16'h001C;
      4'd4:    m = 16'h003C;
      4'd5:    m = 16'h007C;
      4'd6:    m = 16'h00FC;
      4'd7:    m = 16'h04FC;
      4'd8:    m = 16'h0CFC;
      4'd9:    m = 16'h1CFC;
      4'd10:   m = 16'h3CFC;
      4'd11:   m = 16'h7CFC;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/core/mrbce_urom.sv
// Microcode store for the mask run blit code emitter.
// One control word per step; depends on mrbce_pkg.
module mrbce_urom import mrbce_pkg::*; (
  input  logic [UPC_W-1:0] addr_i,
  output ctrl_t            ctrl_o
);

  function automatic ctrl_t cw(input logic e, input src_e s, input logic [15:0] l,
                               input last_e la, input act_e a, input seq_e q,
                               input logic [UPC_W-1:0] t);
    ctrl_t c;
    c.emit = e;
    c.src  = s;
    c.lit  = l;
    c.last = la;
    c.act  = a;
    c.seq  = q;
    c.tgt  = t;
    return c;
  endfunction

  localparam logic [UPC_W-1:0] NT = '0;

  always_comb begin
    case (addr_i)
      5'd0:  ctrl_o = cw(1'b1, SRC_LIT, 16'h48E7, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd1:  ctrl_o = cw(1'b1, SRC_LIT, 16'h1F3E, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd2:  ctrl_o = cw(1'b1, SRC_LIT, 16'h4CEF, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd3:  ctrl_o = cw(1'b1, SRC_LIT, 16'h0303, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd4:  ctrl_o = cw(1'b1, SRC_LIT, 16'h002C, LAST_YES, ACT_NONE, SEQ_DONE, NT);
      5'd5:  ctrl_o = cw(1'b1, SRC_LIT, 16'h4CDF, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd6:  ctrl_o = cw(1'b1, SRC_LIT, 16'h7CF8, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd7:  ctrl_o = cw(1'b1, SRC_LIT, 16'h4E75, LAST_YES, ACT_NONE, SEQ_DONE, NT);
      5'd8:  ctrl_o = cw(1'b0, SRC_LIT, 16'h0000, LAST_NO, ACT_NONE, SEQ_DISPATCH, NT);
      5'd9:  ctrl_o = cw(1'b1, SRC_LIT, 16'h4CE8, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd10: ctrl_o = cw(1'b1, SRC_MASK, 16'h0000, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd11: ctrl_o = cw(1'b1, SRC_OFF, 16'h0000, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd12: ctrl_o = cw(1'b1, SRC_LIT, 16'h48E9, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd13: ctrl_o = cw(1'b1, SRC_MASK, 16'h0000, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd14: ctrl_o = cw(1'b1, SRC_OFF, 16'h0000, LAST_CHUNK, ACT_ADV, SEQ_GOTO, UA_CHUNK);
      5'd15: ctrl_o = cw(1'b1, SRC_LIT, 16'h4CD0, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd16: ctrl_o = cw(1'b1, SRC_MASK, 16'h0000, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd17: ctrl_o = cw(1'b1, SRC_LIT, 16'h48D1, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd18: ctrl_o = cw(1'b1, SRC_MASK, 16'h0000, LAST_CHUNK, ACT_ADV, SEQ_GOTO, UA_CHUNK);
      5'd19: ctrl_o = cw(1'b1, SRC_LOP, 16'h0000, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd20: ctrl_o = cw(1'b1, SRC_OFF, 16'h0000, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd21: ctrl_o = cw(1'b1, SRC_OFF, 16'h0000, LAST_CHUNK, ACT_ADV, SEQ_GOTO, UA_CHUNK);
      5'd22: ctrl_o = cw(1'b1, SRC_SOP, 16'h0000, LAST_CHUNK, ACT_ADV, SEQ_GOTO, UA_CHUNK);
      5'd23: ctrl_o = cw(1'b0, SRC_LIT, 16'h0000, LAST_NO, ACT_NONE, SEQ_TAIL, NT);
      5'd24: ctrl_o = cw(1'b1, SRC_LIT, 16'hD1C0, LAST_NO, ACT_NONE, SEQ_NEXT, NT);
      5'd25: ctrl_o = cw(1'b1, SRC_LIT, 16'hD3C1, LAST_YES, ACT_FIN, SEQ_DONE, NT);
      default: ctrl_o = cw(1'b0, SRC_LIT, 16'h0000, LAST_NO, ACT_NONE, SEQ_DONE, NT);
    endcase
  end

endmodule

// File: rtl/core/mask_run_blit_code_emitter_top.sv
// Top level of the mask run blit code emitter: item handshakes, run and
// offset state, sequencer and output register. Depends on mrbce_pkg and mrbce_urom.
//
// Takes one command or mask byte per item and emits 68000 copy code, at most
// one 16-bit word per cycle while the output is not stalled. An opaque byte that
// neither completes a 44-byte chunk nor ends its line is taken without the
// sequencer, as is an unused command or a pixel past the line length that does
// not end its line. Any other pixel is owned by the microcode sequencer: it is
// accepted, then each chunk of the run gets a dispatch step and its words (one
// to six), then a last dispatch step and a tail step, plus the two row advance
// words at a line end that is not the last line. Output stalls hold the sequencer.
module mask_run_blit_code_emitter_top import mrbce_pkg::*; #(
  parameter int unsigned MAX_LINE_PIXELS = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

  localparam logic [OFF_W:0] LINE_MAX = (OFF_W+1)'(MAX_LINE_PIXELS);

  logic             busy_q, busy_d;
  logic [UPC_W-1:0] pc_q, pc_d;
  logic [RUN_W-1:0] pend_q, pend_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic             flush_q, flush_d;
  logic             inc_q, inc_d;
  logic             adda_q, adda_d;
  logic             clr_q, clr_d;
  logic             ovalid_q, ovalid_d;
  out_t             oitem_q, oitem_d;

  ctrl_t            cw;
  logic             in_fire;
  logic             out_free;
  logic             step_fire;
  logic             room;
  logic             opaque;
  logic [RUN_W-1:0] pend_inc;
  logic             is_movem;
  logic [RUN_W-1:0] size;
  logic [RUN_W-1:0] rem;
  logic [15:0]      lop;
  logic [15:0]      sop;
  logic [15:0]      word;
  logic             last_now;
  logic             fin_now;

  mrbce_urom u_urom (
    .addr_i (pc_q),
    .ctrl_o (cw)
  );

  assign in_stall_o  = busy_q;
  assign in_fire     = in_valid_i && !busy_q;
  assign out_free    = !ovalid_q || !out_stall_i;
  assign step_fire   = busy_q && (!cw.emit || out_free);
  assign out_valid_o = ovalid_q;
  assign out_item_o  = oitem_q;

  assign room     = ({1'b0, off_q} + (OFF_W+1)'(pend_q)) < LINE_MAX;
  assign opaque   = in_item_i.mask_byte != 8'd0;
  assign pend_inc = pend_q + RUN_W'(1);

  always_comb begin
    is_movem = pend_q >= RUN_W'(12);
    if (is_movem) begin
      size = {pend_q[RUN_W-1:2], 2'b00};
      lop  = 16'h0000;
      sop  = 16'h0000;
    end else if (pend_q >= RUN_W'(4)) begin
      size = RUN_W'(4);
      lop  = 16'h2368;
      sop  = 16'h2290;
    end else if (pend_q >= RUN_W'(2)) begin
      size = RUN_W'(2);
      lop  = 16'h3368;
      sop  = 16'h3290;
    end else begin
      size = RUN_W'(1);
      lop  = 16'h1368;
      sop  = 16'h1290;
    end
    rem = pend_q - size;
  end

  always_comb begin
    case (cw.src)
      SRC_LIT:  word = cw.lit;
      SRC_MASK: word = movem_mask(pend_q[RUN_W-1:2]);
      SRC_OFF:  word = {{(16-OFF_W){1'b0}}, off_q};
      SRC_LOP:  word = lop;
      SRC_SOP:  word = sop;
      default:  word = cw.lit;
    endcase
    case (cw.last)
      LAST_YES:   last_now = 1'b1;
      LAST_CHUNK: last_now = (rem == '0) && !adda_q;
      default:    last_now = 1'b0;
    endcase
    fin_now = (cw.act == ACT_FIN) || ((cw.seq == SEQ_TAIL) && !adda_q);
  end

  always_comb begin
    busy_d   = busy_q;
    pc_d     = pc_q;
    pend_d   = pend_q;
    off_d    = off_q;
    flush_d  = flush_q;
    inc_d    = inc_q;
    adda_d   = adda_q;
    clr_d    = clr_q;
    ovalid_d = ovalid_q && out_stall_i;
    oitem_d  = oitem_q;

    if (in_fire) begin
      case (in_item_i.cmd)
        CMD_START: begin
          pend_d = '0;
          off_d  = '0;
          busy_d = 1'b1;
          pc_d   = UA_PRE;
        end
        CMD_FINISH: begin
          pend_d = '0;
          off_d  = '0;
          busy_d = 1'b1;
          pc_d   = UA_POST;
        end
        CMD_PIXEL: begin
          if (room && opaque) begin
            pend_d = pend_inc;
          end
          flush_d = in_item_i.line_end ||
                    (room && (!opaque || pend_inc == RUN_FLUSH));
          inc_d   = room && !opaque;
          adda_d  = in_item_i.line_end && !in_item_i.last_line;
          clr_d   = in_item_i.line_end;
          busy_d  = flush_d;
          pc_d    = UA_CHUNK;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end

    if (step_fire) begin
      if (cw.emit) begin
        ovalid_d          = 1'b1;
        oitem_d.code_word = word;
        oitem_d.last_word = last_now;
      end
      if (cw.act == ACT_ADV) begin
        pend_d = rem;
        off_d  = off_q + OFF_W'(size);
      end
      if (fin_now) begin
        if (clr_q) begin
          pend_d = '0;
          off_d  = '0;
        end else if (inc_q) begin
          off_d = off_q + OFF_W'(1);
        end
      end
      case (cw.seq)
        SEQ_NEXT: pc_d = pc_q + UPC_W'(1);
        SEQ_GOTO: pc_d = cw.tgt;
        SEQ_DONE: busy_d = 1'b0;
        SEQ_DISPATCH: begin
          if (!flush_q || pend_q == '0) begin
            pc_d = UA_TAIL;
          end else if (is_movem) begin
            pc_d = (off_q != '0) ? UA_M_OFF : UA_M_0;
          end else begin
            pc_d = (off_q != '0) ? UA_S_OFF : UA_S_0;
          end
        end
        SEQ_TAIL: begin
          if (adda_q) begin
            pc_d = pc_q + UPC_W'(1);
          end else begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pc_q     <= '0;
      pend_q   <= '0;
      off_q    <= '0;
      flush_q  <= 1'b0;
      inc_q    <= 1'b0;
      adda_q   <= 1'b0;
      clr_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pc_q     <= pc_d;
      pend_q   <= pend_d;
      off_q    <= off_d;
      flush_q  <= flush_d;
      inc_q    <= inc_d;
      adda_q   <= adda_d;
      clr_q    <= clr_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oitem_q <= oitem_d;
  end

  // A run never rests at the flush length between items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> pend_q < RUN_FLUSH)
    else $error("run left pending at flush length");

  // The offset plus the pending run never passes the line length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, off_q} + (OFF_W+1)'(pend_q)) <= LINE_MAX)
    else $error("line position beyond line length");

  // A word emitted by a step that ends the program closes its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && cw.emit && cw.seq == SEQ_DONE |=> out_valid_o && out_item_o.last_word)
    else $error("final step emitted a word without the last flag");

endmodule
